>>> design/cartesian_to_cylindrical_offset_macros.svh
`ifndef CARTESIAN_TO_CYLINDRICAL_OFFSET_MACROS_SVH
`define CARTESIAN_TO_CYLINDRICAL_OFFSET_MACROS_SVH

// check a property while out of reset
`define C2C_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property at every edge, reset included
`define C2C_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/c2c_pkg.sv
`default_nettype none

package c2c_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int GUARD_BITS = 8;
  localparam int CW = 44;
  localparam int PW = CW - 1 + 16;
  localparam int AW = 4;
  localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
  localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;

  typedef enum logic [1:0] {
    REG_SRC_AZIMUTH = 2'd0,
    REG_TGT_AZIMUTH = 2'd1,
    REG_SRC_HEIGHT  = 2'd2,
    REG_TGT_HEIGHT  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [31:0] src_azimuth;
    logic [31:0] tgt_azimuth;
    logic [31:0] src_height;
    logic [31:0] tgt_height;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [31:0]   ang;
    logic [31:0]   zeta;
    logic          sat;
    logic          origin;
  } cord_t;

  typedef struct packed {
    logic [PW-1:0] p;
    logic [PW-1:0] q;
    logic          pos;
    logic [31:0]   ang;
    logic [31:0]   zeta;
    logic          sat;
    logic          origin;
  } prod_t;

  typedef struct packed {
    logic [31:0] theta;
    logic [31:0] rho;
    logic [31:0] zeta;
    logic        sat;
  } res_t;

  function automatic logic [31:0] atan_entry(input logic [5:0] idx);
    logic [31:0] a;
    case (idx)
      6'd0:  a = 32'd536870912;
      6'd1:  a = 32'd316933406;
      6'd2:  a = 32'd167458907;
      6'd3:  a = 32'd85004756;
      6'd4:  a = 32'd42667331;
      6'd5:  a = 32'd21354465;
      6'd6:  a = 32'd10679838;
      6'd7:  a = 32'd5340245;
      6'd8:  a = 32'd2670163;
      6'd9:  a = 32'd1335087;
      6'd10: a = 32'd667544;
      6'd11: a = 32'd333772;
      6'd12: a = 32'd166886;
      6'd13: a = 32'd83443;
      6'd14: a = 32'd41722;
      6'd15: a = 32'd20861;
      6'd16: a = 32'd10430;
      6'd17: a = 32'd5215;
      6'd18: a = 32'd2608;
      6'd19: a = 32'd1304;
      6'd20: a = 32'd652;
      6'd21: a = 32'd326;
      6'd22: a = 32'd163;
      6'd23: a = 32'd81;
      6'd24: a = 32'd41;
      6'd25: a = 32'd20;
      6'd26: a = 32'd10;
      6'd27: a = 32'd5;
      6'd28: a = 32'd3;
      6'd29: a = 32'd1;
      6'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> design/cartesian_to_cylindrical_offset.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | x_in_i, y_in_i, z_in_i
// out     | output    | out_valid_o / out_ready_i| theta_out_o, rho_out_o, zeta_out_o,
//         |           |                          | saturated_o
// cfg     | input     | psel, penable, pwrite    | paddr, pwdata, prdata, pready
//
// One item per cycle while the output is not stalled; stages: one entry stage,
// one stage per CORDIC step, one multiply stage and one round/clamp stage.
// Reset clears all valid bits and the four offset registers to zero.
// Each stage holds its item while the next one is full and stalled;
// bubbles close up under a stall.
`default_nettype none

module cartesian_to_cylindrical_offset #(
  parameter int CORDIC_ITERATIONS = c2c_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [31:0]       x_in_i,
  input  wire logic signed [31:0]       y_in_i,
  input  wire logic signed [31:0]       z_in_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [31:0]            theta_out_o,
  output logic [31:0]                   rho_out_o,
  output logic signed [31:0]            zeta_out_o,
  output logic                          saturated_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [c2c_pkg::AW-1:0]   paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  c2c_pkg::cfg_t  cfg_q, cfg_d;
  c2c_pkg::reg_e  sel;
  c2c_pkg::cord_t chain [CORDIC_ITERATIONS+1];
  logic [CORDIC_ITERATIONS:0] vld;
  logic [CORDIC_ITERATIONS:0] rdy;
  c2c_pkg::res_t  res;

  assign pready = 1'b1;
  assign sel = c2c_pkg::reg_e'(paddr[c2c_pkg::AW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (sel)
        c2c_pkg::REG_SRC_AZIMUTH: cfg_d.src_azimuth = pwdata;
        c2c_pkg::REG_TGT_AZIMUTH: cfg_d.tgt_azimuth = pwdata;
        c2c_pkg::REG_SRC_HEIGHT:  cfg_d.src_height  = pwdata;
        c2c_pkg::REG_TGT_HEIGHT:  cfg_d.tgt_height  = pwdata;
        default: cfg_d = cfg_q;
      endcase
    end
    case (sel)
      c2c_pkg::REG_SRC_AZIMUTH: prdata = cfg_q.src_azimuth;
      c2c_pkg::REG_TGT_AZIMUTH: prdata = cfg_q.tgt_azimuth;
      c2c_pkg::REG_SRC_HEIGHT:  prdata = cfg_q.src_height;
      c2c_pkg::REG_TGT_HEIGHT:  prdata = cfg_q.tgt_height;
      default: prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  c2c_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .x_i     (x_in_i),
    .y_i     (y_in_i),
    .z_i     (z_in_i),
    .cfg_i   (cfg_q),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .data_o  (chain[0])
  );

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_step
    c2c_stage #(
      .IDX (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .data_i  (chain[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .data_o  (chain[i+1])
    );
  end

  c2c_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[CORDIC_ITERATIONS]),
    .ready_o (rdy[CORDIC_ITERATIONS]),
    .data_i  (chain[CORDIC_ITERATIONS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res)
  );

  assign theta_out_o = res.theta;
  assign rho_out_o   = res.rho;
  assign zeta_out_o  = res.zeta;
  assign saturated_o = res.sat;

endmodule

`default_nettype wire

>>> design/c2c_pre.sv
`default_nettype none

module c2c_pre (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic signed [31:0]  x_i,
  input  wire logic signed [31:0]  y_i,
  input  wire logic signed [31:0]  z_i,
  input  wire c2c_pkg::cfg_t       cfg_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output c2c_pkg::cord_t           data_o
);

  localparam int PadW = c2c_pkg::CW - 33 - c2c_pkg::GUARD_BITS;

  logic           vld_q, vld_d;
  c2c_pkg::cord_t data_q, data_d;
  logic           neg;
  logic [32:0]    x33, y33, xa, ya;
  logic [33:0]    z34;
  logic           over;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    neg = x_i[31];
    x33 = {x_i[31], x_i};
    y33 = {y_i[31], y_i};
    xa  = neg ? 33'(-x33) : x33;
    ya  = neg ? 33'(-y33) : y33;
    z34 = {{2{z_i[31]}}, z_i} - {{2{cfg_i.src_height[31]}}, cfg_i.src_height}
        + {{2{cfg_i.tgt_height[31]}}, cfg_i.tgt_height};
    over = (z34[33:31] != 3'b000) && (z34[33:31] != 3'b111);

    data_d.x = {{PadW{xa[32]}}, xa, {c2c_pkg::GUARD_BITS{1'b0}}};
    data_d.y = {{PadW{ya[32]}}, ya, {c2c_pkg::GUARD_BITS{1'b0}}};
    data_d.ang = (neg ? 32'h8000_0000 : 32'h0) + cfg_i.tgt_azimuth - cfg_i.src_azimuth;
    data_d.origin = (x_i == 32'sd0) && (y_i == 32'sd0);
    if (data_d.origin) begin
      data_d.zeta = z_i;
      data_d.sat  = 1'b0;
    end else if (over) begin
      data_d.zeta = z34[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      data_d.sat  = 1'b1;
    end else begin
      data_d.zeta = z34[31:0];
      data_d.sat  = 1'b0;
    end
    vld_d = ready_o ? valid_i : vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

>>> design/c2c_stage.sv
`default_nettype none

module c2c_stage #(
  parameter int IDX = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire c2c_pkg::cord_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output c2c_pkg::cord_t      data_o
);

  logic                        vld_q, vld_d;
  c2c_pkg::cord_t              data_q, data_d;
  logic signed [c2c_pkg::CW-1:0] dx, dy;
  logic [31:0]                 a;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    dx = $signed(data_i.y) >>> IDX;
    dy = $signed(data_i.x) >>> IDX;
    a  = c2c_pkg::atan_entry(6'(IDX));
    data_d = data_i;
    if (!data_i.y[c2c_pkg::CW-1]) begin
      data_d.x   = data_i.x + dx;
      data_d.y   = data_i.y - dy;
      data_d.ang = data_i.ang + a;
    end else begin
      data_d.x   = data_i.x - dx;
      data_d.y   = data_i.y + dy;
      data_d.ang = data_i.ang - a;
    end
    vld_d = ready_o ? valid_i : vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

>>> design/c2c_scale.sv
`default_nettype none

module c2c_scale (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire c2c_pkg::cord_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output c2c_pkg::res_t       res_o
);

  localparam int PW = c2c_pkg::PW;
  localparam int TW = c2c_pkg::PW + 1;
  localparam int Shift = 16 + c2c_pkg::GUARD_BITS;
  localparam logic [TW-1:0] Half = TW'(1) << (Shift - 1);

  logic           vld_a_q, vld_a_d, vld_b_q, vld_b_d;
  logic           rdy_a;
  c2c_pkg::prod_t prod_q, prod_d;
  c2c_pkg::res_t  res_q, res_d;
  logic [c2c_pkg::CW-2:0] ux;
  logic [TW-1:0]  t;
  logic [TW-Shift-1:0] r;

  assign rdy_a   = !vld_b_q || ready_i;
  assign ready_o = !vld_a_q || rdy_a;
  assign valid_o = vld_b_q;
  assign res_o   = res_q;

  always_comb begin
    ux = data_i.x[c2c_pkg::CW-2:0];
    prod_d.p = PW'(ux) * PW'(c2c_pkg::INV_GAIN_HI);
    prod_d.q = PW'(ux) * PW'(c2c_pkg::INV_GAIN_LO);
    prod_d.pos = !data_i.x[c2c_pkg::CW-1] && (data_i.x != '0);
    prod_d.ang = data_i.ang;
    prod_d.zeta = data_i.zeta;
    prod_d.sat = data_i.sat;
    prod_d.origin = data_i.origin;
    vld_a_d = ready_o ? valid_i : vld_a_q;
  end

  always_comb begin
    t = {1'b0, prod_q.p} + TW'(prod_q.q >> 16) + Half;
    r = t[TW-1:Shift];
    if (prod_q.origin || !prod_q.pos) begin
      res_d.rho = 32'h0;
    end else if (r > (TW-Shift)'(32'hFFFF_FFFF)) begin
      res_d.rho = 32'hFFFF_FFFF;
    end else begin
      res_d.rho = r[31:0];
    end
    res_d.theta = prod_q.origin ? 32'h0 : prod_q.ang;
    res_d.zeta  = prod_q.zeta;
    res_d.sat   = prod_q.sat;
    vld_b_d = rdy_a ? vld_a_q : vld_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= vld_a_d;
      vld_b_q <= vld_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
    if (vld_a_q && rdy_a) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> design/c2c_checker.sv
`default_nettype none

`include "cartesian_to_cylindrical_offset_macros.svh"

module c2c_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic signed [31:0]     x_in_i,
  input wire logic signed [31:0]     y_in_i,
  input wire logic signed [31:0]     z_in_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic signed [31:0]     theta_out_o,
  input wire logic [31:0]            rho_out_o,
  input wire logic signed [31:0]     zeta_out_o,
  input wire logic                   saturated_o,
  input wire logic                   psel,
  input wire logic                   penable,
  input wire logic                   pwrite,
  input wire logic [c2c_pkg::AW-1:0] paddr,
  input wire logic [31:0]            pwdata,
  input wire logic [31:0]            prdata,
  input wire logic                   pready
);

  logic [95:0] in_bus;
  logic [96:0] out_bus;
  logic        in_wait;
  logic        out_wait;
  logic        zeta_clamped;
  logic        cfg_wr;

  assign in_bus       = {x_in_i, y_in_i, z_in_i};
  assign out_bus      = {theta_out_o, rho_out_o, zeta_out_o, saturated_o};
  assign in_wait      = in_valid_i && !in_ready_o;
  assign out_wait     = out_valid_o && !out_ready_i;
  assign zeta_clamped = (zeta_out_o == 32'sh7FFF_FFFF) || (zeta_out_o == 32'sh8000_0000);
  assign cfg_wr       = psel && penable && pwrite && pready;

  `C2C_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "output valid during reset")

  `C2C_ASSERT(a_in_hold, in_wait |=> in_valid_i && $stable(in_bus), "waiting item changed")

  `C2C_ASSERT(a_sat_clamped, out_valid_o && saturated_o |-> zeta_clamped, "unclamped zeta")

  `C2C_ASSERT(a_out_hold, out_wait |=> out_valid_o && $stable(out_bus), "stalled item changed")

  `C2C_ASSERT(a_readback, cfg_wr ##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata), "bad readback")

endmodule

bind cartesian_to_cylindrical_offset c2c_checker u_c2c_checker (.*);

`default_nettype wire
